/* hdl/rosi_pkg.sv */
// Shared constants and types for the segment / oriented box intersection block.
// No dependencies; imported by every module in hdl/.
`timescale 1ns / 1ps
`default_nettype none

package rosi_pkg;

  localparam int FIELD_WIDTH    = 48;   // every input field
  localparam int NUM_FIELDS     = 7;
  localparam int IN_TDATA_W     = FIELD_WIDTH * NUM_FIELDS;
  localparam int OUT_TDATA_W    = 24;   // hit + 16-bit fraction, padded to bytes
  localparam int AXIS_WIDTH     = 16;   // Q1.14 axis components
  localparam int AXIS_FRAC_BITS = 14;
  localparam int FRAC_OUT_BITS  = 16;   // Q0.16 result
  localparam int DIV_STEPS      = 2;    // quotient bits per divider stage
  localparam int DIV_STAGES     = FRAC_OUT_BITS / DIV_STEPS;

  // sign of p1/q1 - p2/q2
  typedef struct packed {
    logic gt;
    logic lt;
  } cmp_res_t;

endpackage

`default_nettype wire

/* hdl/ray_obb_segment_intersect.sv */
// Segment versus oriented box slab test, exact rational compare, Q0.16 hit fraction.
// One beat per cycle sustained while m_axis_tready holds high, through the
// 18-stage pipeline (projection, slab merge compares, 8-stage divider).
// Each stage loads when empty or when the next stage moves, so bubbles close up.
// Reset (rst_ni low, asynchronous) clears the stage valid bits only.
// Depends on rosi_pkg, rosi_frac_cmp and rosi_div.
`timescale 1ns / 1ps
`default_nettype none

module ray_obb_segment_intersect #(
  parameter int COORD_WIDTH = 16
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // ray_origin, ray_dest, box_center, box_axis_u, box_axis_v, box_axis_w,
  // box_half_lengths; 48 bits each from bit 0 up
  input  wire  [rosi_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // hit [0], hit_fraction [16:1], zeros [23:17]
  output logic [rosi_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
  import rosi_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int DW  = W + 1;
  localparam int PW  = DW + AXIS_WIDTH;
  localparam int DDW = PW + 2;
  localparam int HSW = W + AXIS_FRAC_BITS;
  localparam int LW  = DDW + 1;
  localparam int QW  = DDW;
  localparam int NST = 10 + DIV_STAGES;

  typedef struct packed {
    logic                 bnd;
    logic signed [LW-1:0] lo;
    logic signed [LW-1:0] hi;
    logic        [QW-1:0] q;
  } slab_t;

  typedef struct packed {
    logic                 bnd;
    logic signed [LW-1:0] en_p;
    logic        [QW-1:0] en_q;
    logic signed [LW-1:0] ex_p;
    logic        [QW-1:0] ex_q;
  } acc_t;

  function automatic logic [W-1:0] lane(input logic [FIELD_WIDTH-1:0] f, input int k);
    logic [3*W+FIELD_WIDTH-1:0] e;
    e = {{(3*W){1'b0}}, f};
    return e[k*W +: W];
  endfunction

  function automatic acc_t merge(input acc_t a, input slab_t b,
                                 input cmp_res_t ren, input cmp_res_t rex);
    acc_t m;
    m = a;
    if (!a.bnd) begin
      m.bnd  = b.bnd;
      m.en_p = b.lo;
      m.en_q = b.q;
      m.ex_p = b.hi;
      m.ex_q = b.q;
    end else if (b.bnd) begin
      if (ren.gt) begin
        m.en_p = b.lo;
        m.en_q = b.q;
      end
      if (rex.lt) begin
        m.ex_p = b.hi;
        m.ex_q = b.q;
      end
    end
    return m;
  endfunction

  // ---------------- valid bits and stage enables ----------------
  logic [NST-1:0] v_q;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v_q[NST-1] || m_axis_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign s_axis_tready = en[0];

  // ---------------- stage 0: unpack, d = dest - origin, c = centre - origin
  logic [W-1:0] org [3];
  logic [W-1:0] dst [3];
  logic [W-1:0] ctr [3];

  logic signed [DW-1:0]         d0_q  [3];
  logic signed [DW-1:0]         c0_q  [3];
  logic signed [AXIS_WIDTH-1:0] ax0_q [3][3];
  logic        [W-1:0]          hl0_q [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      org[j] = lane(s_axis_tdata[0*FIELD_WIDTH +: FIELD_WIDTH], j);
      dst[j] = lane(s_axis_tdata[1*FIELD_WIDTH +: FIELD_WIDTH], j);
      ctr[j] = lane(s_axis_tdata[2*FIELD_WIDTH +: FIELD_WIDTH], j);
    end
  end

  // ---------------- stage 1: axis projections, products
  logic signed [PW-1:0] pd1_q [3][3];
  logic signed [PW-1:0] pc1_q [3][3];
  logic        [W-1:0]  hl1_q [3];

  // ---------------- stage 2: sums
  logic signed [DDW-1:0] dd2_q [3];
  logic signed [DDW-1:0] oc2_q [3];
  logic        [HSW-1:0] hs2_q [3];

  // ---------------- stage 3: slab intervals
  logic signed [LW-1:0] ocx [3];
  logic signed [LW-1:0] hsx [3];
  logic signed [DDW-1:0] ddn [3];
  slab_t iv3_d [3];
  logic  rej3_d;
  slab_t iv3_q [3];
  logic  rej3_q;

  always_comb begin
    rej3_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ocx[i] = LW'(oc2_q[i]);
      hsx[i] = $signed({{(LW-HSW){1'b0}}, hs2_q[i]});
      ddn[i] = -dd2_q[i];
      iv3_d[i].bnd = |dd2_q[i];
      if (dd2_q[i][DDW-1]) begin
        iv3_d[i].lo = -(ocx[i] + hsx[i]);
        iv3_d[i].hi = hsx[i] - ocx[i];
        iv3_d[i].q  = QW'(ddn[i]);
      end else begin
        iv3_d[i].lo = ocx[i] - hsx[i];
        iv3_d[i].hi = ocx[i] + hsx[i];
        iv3_d[i].q  = QW'(dd2_q[i]);
      end
      // parallel axis: origin must lie inside the slab
      if (!iv3_d[i].bnd && ((ocx[i] > hsx[i]) || (ocx[i] < -hsx[i]))) begin
        rej3_d = 1'b1;
      end
    end
  end

  // ---------------- stages 4..9: merge slabs, final checks
  cmp_res_t res_en_a, res_ex_a, res_en_b, res_ex_b, res_c;

  acc_t  acc4_q;
  slab_t b4_q, w4_q;
  logic  rej4_q;
  acc_t  acc5_q;
  slab_t w5_q;
  logic  rej5_q;
  acc_t  acc6_q;
  slab_t b6_q;
  logic  rej6_q;
  acc_t  acc7_q;
  logic  rej7_q;
  acc_t  acc8_q;
  logic  rej8_q;

  logic                 fin_hit_d, fin_hit_q;
  logic        [QW-1:0] fin_tp_d, fin_tp_q;
  logic        [QW-1:0] fin_tq_d, fin_tq_q;
  logic signed [LW-1:0] t_p;
  logic        [QW-1:0] t_q;
  logic                 miss;

  rosi_frac_cmp #(.PW(LW), .QW(QW)) u_cmp_en_a (
    .clk_i (clk_i), .en_i (en[4]),
    .p1_i (iv3_q[1].lo), .q1_i (iv3_q[1].q),
    .p2_i (iv3_q[0].lo), .q2_i (iv3_q[0].q),
    .res_o (res_en_a)
  );

  rosi_frac_cmp #(.PW(LW), .QW(QW)) u_cmp_ex_a (
    .clk_i (clk_i), .en_i (en[4]),
    .p1_i (iv3_q[1].hi), .q1_i (iv3_q[1].q),
    .p2_i (iv3_q[0].hi), .q2_i (iv3_q[0].q),
    .res_o (res_ex_a)
  );

  rosi_frac_cmp #(.PW(LW), .QW(QW)) u_cmp_en_b (
    .clk_i (clk_i), .en_i (en[6]),
    .p1_i (w5_q.lo), .q1_i (w5_q.q),
    .p2_i (acc5_q.en_p), .q2_i (acc5_q.en_q),
    .res_o (res_en_b)
  );

  rosi_frac_cmp #(.PW(LW), .QW(QW)) u_cmp_ex_b (
    .clk_i (clk_i), .en_i (en[6]),
    .p1_i (w5_q.hi), .q1_i (w5_q.q),
    .p2_i (acc5_q.ex_p), .q2_i (acc5_q.ex_q),
    .res_o (res_ex_b)
  );

  // entry against exit
  rosi_frac_cmp #(.PW(LW), .QW(QW)) u_cmp_c (
    .clk_i (clk_i), .en_i (en[8]),
    .p1_i (acc7_q.en_p), .q1_i (acc7_q.en_q),
    .p2_i (acc7_q.ex_p), .q2_i (acc7_q.ex_q),
    .res_o (res_c)
  );

  always_comb begin
    t_p  = acc8_q.en_p[LW-1] ? acc8_q.ex_p : acc8_q.en_p;
    t_q  = acc8_q.en_p[LW-1] ? acc8_q.ex_q : acc8_q.en_q;
    miss = rej8_q || !acc8_q.bnd || acc8_q.ex_p[LW-1] || res_c.gt
        || (t_p >= $signed({1'b0, t_q}));
    fin_hit_d = !miss;
    fin_tp_d  = miss ? '0 : t_p[QW-1:0];
    fin_tq_d  = miss ? QW'(1) : t_q;   // non-zero divisor keeps the quotient at zero
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int j = 0; j < 3; j++) begin
        d0_q[j]  <= {dst[j][W-1], dst[j]} - {org[j][W-1], org[j]};
        c0_q[j]  <= {ctr[j][W-1], ctr[j]} - {org[j][W-1], org[j]};
        hl0_q[j] <= lane(s_axis_tdata[6*FIELD_WIDTH +: FIELD_WIDTH], j);
        for (int i = 0; i < 3; i++) begin
          ax0_q[i][j] <= s_axis_tdata[(3+i)*FIELD_WIDTH + j*AXIS_WIDTH +: AXIS_WIDTH];
        end
      end
    end
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        hl1_q[i] <= hl0_q[i];
        for (int j = 0; j < 3; j++) begin
          pd1_q[i][j] <= ax0_q[i][j] * d0_q[j];
          pc1_q[i][j] <= ax0_q[i][j] * c0_q[j];
        end
      end
    end
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        dd2_q[i] <= DDW'(pd1_q[i][0]) + DDW'(pd1_q[i][1]) + DDW'(pd1_q[i][2]);
        oc2_q[i] <= DDW'(pc1_q[i][0]) + DDW'(pc1_q[i][1]) + DDW'(pc1_q[i][2]);
        hs2_q[i] <= {hl1_q[i], {AXIS_FRAC_BITS{1'b0}}};
      end
    end
    if (en[3]) begin
      iv3_q  <= iv3_d;
      rej3_q <= rej3_d;
    end
    if (en[4]) begin
      acc4_q.bnd  <= iv3_q[0].bnd;
      acc4_q.en_p <= iv3_q[0].lo;
      acc4_q.en_q <= iv3_q[0].q;
      acc4_q.ex_p <= iv3_q[0].hi;
      acc4_q.ex_q <= iv3_q[0].q;
      b4_q        <= iv3_q[1];
      w4_q        <= iv3_q[2];
      rej4_q      <= rej3_q;
    end
    if (en[5]) begin
      acc5_q <= merge(acc4_q, b4_q, res_en_a, res_ex_a);
      w5_q   <= w4_q;
      rej5_q <= rej4_q;
    end
    if (en[6]) begin
      acc6_q <= acc5_q;
      b6_q   <= w5_q;
      rej6_q <= rej5_q;
    end
    if (en[7]) begin
      acc7_q <= merge(acc6_q, b6_q, res_en_b, res_ex_b);
      rej7_q <= rej6_q;
    end
    if (en[8]) begin
      acc8_q <= acc7_q;
      rej8_q <= rej7_q;
    end
    if (en[9]) begin
      fin_hit_q <= fin_hit_d;
      fin_tp_q  <= fin_tp_d;
      fin_tq_q  <= fin_tq_d;
    end
  end

  // ---------------- stages 10..17: fraction divider, last stage is the output register
  logic                     out_hit;
  logic [FRAC_OUT_BITS-1:0] out_frac;

  rosi_div #(.QW(QW)) u_div (
    .clk_i  (clk_i),
    .en_i   (en[NST-1:10]),
    .hit_i  (fin_hit_q),
    .tp_i   (fin_tp_q),
    .tq_i   (fin_tq_q),
    .hit_o  (out_hit),
    .quot_o (out_frac)
  );

  assign m_axis_tvalid = v_q[NST-1];
  assign m_axis_tdata  = {{(OUT_TDATA_W-FRAC_OUT_BITS-1){1'b0}}, out_frac, out_hit};

  // ---------------- checks
  a_miss_zero_frac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[FRAC_OUT_BITS:1] == '0))
    else $error("miss beat carries a non-zero fraction");

  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  a_hit_below_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[9] && fin_hit_q) |-> (fin_tp_q < fin_tq_q))
    else $error("hit value not below segment length at divider input");

  a_stall_holds_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready && !s_axis_tready) |=> $stable(v_q))
    else $error("pipeline moved while fully stalled");

endmodule

`default_nettype wire

/* hdl/rosi_frac_cmp.sv */
// Exact comparison of two rationals p1/q1 and p2/q2 (q > 0) by cross products.
// One register stage of split partial products, then sum and compare. Uses rosi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rosi_frac_cmp #(
  parameter int PW = 36,
  parameter int QW = 35
) (
  input  wire                   clk_i,
  input  wire                   en_i,
  input  wire  signed [PW-1:0]  p1_i,
  input  wire         [QW-1:0]  q1_i,
  input  wire  signed [PW-1:0]  p2_i,
  input  wire         [QW-1:0]  q2_i,
  output rosi_pkg::cmp_res_t    res_o
);
  import rosi_pkg::*;

  localparam int AL = (PW + 1) / 2;
  localparam int AH = PW - AL;
  localparam int BL = (QW + 1) / 2;
  localparam int BH = QW - BL;
  localparam int RW = PW + QW;

  logic          neg1, neg2, pos1, pos2;
  logic [PW-1:0] m1, m2;

  logic                neg1_q, neg2_q, pos1_q, pos2_q;
  logic [AH+BH-1:0]    hh1_q, hh2_q;
  logic [AH+BL-1:0]    hl1_q, hl2_q;
  logic [AL+BH-1:0]    lh1_q, lh2_q;
  logic [AL+BL-1:0]    ll1_q, ll2_q;

  logic [RW-1:0] prod1, prod2;
  logic          z1, z2;

  always_comb begin
    neg1 = p1_i[PW-1];
    neg2 = p2_i[PW-1];
    pos1 = !neg1 && (|p1_i);
    pos2 = !neg2 && (|p2_i);
    m1   = neg1 ? (~p1_i + PW'(1)) : p1_i;
    m2   = neg2 ? (~p2_i + PW'(1)) : p2_i;
  end

  // |p1|*q2 against |p2|*q1, each split into four narrow products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= neg1;
      neg2_q <= neg2;
      pos1_q <= pos1;
      pos2_q <= pos2;
      hh1_q  <= m1[PW-1:AL] * q2_i[QW-1:BL];
      hl1_q  <= m1[PW-1:AL] * q2_i[BL-1:0];
      lh1_q  <= m1[AL-1:0]  * q2_i[QW-1:BL];
      ll1_q  <= m1[AL-1:0]  * q2_i[BL-1:0];
      hh2_q  <= m2[PW-1:AL] * q1_i[QW-1:BL];
      hl2_q  <= m2[PW-1:AL] * q1_i[BL-1:0];
      lh2_q  <= m2[AL-1:0]  * q1_i[QW-1:BL];
      ll2_q  <= m2[AL-1:0]  * q1_i[BL-1:0];
    end
  end

  always_comb begin
    prod1 = (RW'(hh1_q) << (AL + BL)) + (RW'(hl1_q) << AL) + (RW'(lh1_q) << BL)
          + RW'(ll1_q);
    prod2 = (RW'(hh2_q) << (AL + BL)) + (RW'(hl2_q) << AL) + (RW'(lh2_q) << BL)
          + RW'(ll2_q);
    z1 = !pos1_q && !neg1_q;
    z2 = !pos2_q && !neg2_q;
    res_o.gt = (pos1_q && !pos2_q) || (z1 && neg2_q)
             || (pos1_q && pos2_q && (prod1 > prod2))
             || (neg1_q && neg2_q && (prod1 < prod2));
    res_o.lt = (pos2_q && !pos1_q) || (z2 && neg1_q)
             || (pos1_q && pos2_q && (prod1 < prod2))
             || (neg1_q && neg2_q && (prod1 > prod2));
  end

endmodule

`default_nettype wire

/* hdl/rosi_div.sv */
// Pipelined restoring divider: floor(tp * 2^16 / tq) for tp < tq.
// DIV_STEPS quotient bits per stage, DIV_STAGES stages. Uses rosi_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rosi_div #(
  parameter int QW = 35
) (
  input  wire                                   clk_i,
  input  wire  [rosi_pkg::DIV_STAGES-1:0]       en_i,
  input  wire                                   hit_i,
  input  wire  [QW-1:0]                         tp_i,
  input  wire  [QW-1:0]                         tq_i,
  output logic                                  hit_o,
  output logic [rosi_pkg::FRAC_OUT_BITS-1:0]    quot_o
);
  import rosi_pkg::*;

  logic [QW-1:0]            r_in   [DIV_STAGES];
  logic [QW-1:0]            q_in   [DIV_STAGES];
  logic [FRAC_OUT_BITS-1:0] qt_in  [DIV_STAGES];
  logic                     hit_in [DIV_STAGES];

  logic [QW-1:0]            r_d  [DIV_STAGES];
  logic [FRAC_OUT_BITS-1:0] qt_d [DIV_STAGES];

  logic [QW-1:0]            r_q   [DIV_STAGES];
  logic [QW-1:0]            q_q   [DIV_STAGES];
  logic [FRAC_OUT_BITS-1:0] qt_q  [DIV_STAGES];
  logic                     hit_q [DIV_STAGES];

  always_comb begin
    r_in[0]   = tp_i;
    q_in[0]   = tq_i;
    qt_in[0]  = '0;
    hit_in[0] = hit_i;
    for (int s = 1; s < DIV_STAGES; s++) begin
      r_in[s]   = r_q[s-1];
      q_in[s]   = q_q[s-1];
      qt_in[s]  = qt_q[s-1];
      hit_in[s] = hit_q[s-1];
    end
  end

  always_comb begin
    logic [QW:0]              r2;
    logic [QW-1:0]            r;
    logic [FRAC_OUT_BITS-1:0] qt;
    for (int s = 0; s < DIV_STAGES; s++) begin
      r  = r_in[s];
      qt = qt_in[s];
      for (int k = 0; k < DIV_STEPS; k++) begin
        r2 = {r, 1'b0};
        if (r2 >= {1'b0, q_in[s]}) begin
          r2 = r2 - {1'b0, q_in[s]};
          qt = {qt[FRAC_OUT_BITS-2:0], 1'b1};
        end else begin
          qt = {qt[FRAC_OUT_BITS-2:0], 1'b0};
        end
        r = r2[QW-1:0];
      end
      r_d[s]  = r;
      qt_d[s] = qt;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (en_i[s]) begin
        r_q[s]   <= r_d[s];
        q_q[s]   <= q_in[s];
        qt_q[s]  <= qt_d[s];
        hit_q[s] <= hit_in[s];
      end
    end
  end

  assign hit_o  = hit_q[DIV_STAGES-1];
  assign quot_o = qt_q[DIV_STAGES-1];

endmodule

`default_nettype wire

/* tb/tb_ray_obb_segment_intersect.sv */
// Testbench for ray_obb_segment_intersect: stream driver and monitor, exact slab-test predictor.
// Depends on rosi_pkg and the block under hdl/.
`timescale 1ns / 1ps

module tb_ray_obb_segment_intersect;
  import rosi_pkg::*;

  localparam int CW = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  typedef struct packed {
    logic        hit;
    logic [15:0] frac;
  } isect_t;

  logic [IN_TDATA_W-1:0] pending_q[$];
  isect_t hits_due_q[$];
  int errors = 0;
  int phase = 0;            // 0: 32/80 idling, 1: 80/32, 2: none
  int hold_cycles = 0;      // receiver hold-off counter
  bit hold_req = 0;
  bit hold_taken = 0;

  ray_obb_segment_intersect #(.COORD_WIDTH(CW)) DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint lane_s(logic [47:0] v, int k, int w);
    logic [47:0] x;
    x = (v >> (k * w)) & ((48'd1 << w) - 1);
    if (x[w-1]) return longint'(x) - (longint'(1) << w);
    return longint'(x);
  endfunction

  // sign of p1/q1 - p2/q2, q positive; 128-bit products keep it exact
  function automatic int ratio_cmp(longint p1, longint q1, longint p2, longint q2);
    logic signed [127:0] a, b;
    a = 128'(signed'(p1)) * 128'(signed'(q2));
    b = 128'(signed'(p2)) * 128'(signed'(q1));
    return (a > b) ? 1 : (a < b) ? -1 : 0;
  endfunction

  function automatic isect_t predict_isect(logic [IN_TDATA_W-1:0] beat);
    logic [47:0] f[7];
    longint d[3], c[3], dd, oc, hs, lo, hi, q, o;
    longint en_p, en_q, ex_p, ex_q, t_p, t_q, a;
    bit bounded;
    isect_t r;
    r = '0; bounded = 0;
    en_p = 0; en_q = 1; ex_p = 0; ex_q = 1;
    for (int k = 0; k < 7; k++) f[k] = beat[k*FIELD_WIDTH +: FIELD_WIDTH];
    for (int j = 0; j < 3; j++) begin
      o = lane_s(f[0], j, CW);
      d[j] = lane_s(f[1], j, CW) - o;
      c[j] = lane_s(f[2], j, CW) - o;
    end
    for (int i = 0; i < 3; i++) begin
      dd = 0; oc = 0;
      for (int j = 0; j < 3; j++) begin
        a = lane_s(f[3+i], j, AXIS_WIDTH);
        dd += a * d[j];
        oc += a * c[j];
      end
      hs = longint'((f[6] >> (i * CW)) & ((48'd1 << CW) - 1)) << AXIS_FRAC_BITS;
      if (dd == 0) begin
        if (oc > hs || oc < -hs) return r;
        continue;
      end
      if (dd > 0) begin
        lo = oc - hs; hi = oc + hs; q = dd;
      end else begin
        lo = -(oc + hs); hi = hs - oc; q = -dd;
      end
      if (!bounded) begin
        en_p = lo; en_q = q; ex_p = hi; ex_q = q; bounded = 1;
      end else begin
        if (ratio_cmp(lo, q, en_p, en_q) > 0) begin en_p = lo; en_q = q; end
        if (ratio_cmp(hi, q, ex_p, ex_q) < 0) begin ex_p = hi; ex_q = q; end
      end
    end
    if (!bounded || ex_p < 0) return r;
    if (ratio_cmp(en_p, en_q, ex_p, ex_q) > 0) return r;
    if (en_p >= 0) begin t_p = en_p; t_q = en_q; end
    else begin t_p = ex_p; t_q = ex_q; end
    if (t_p >= t_q) return r;
    r.hit = 1'b1;
    r.frac = 16'((t_p << 16) / t_q);
    return r;
  endfunction

  function automatic logic [47:0] pack3(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic logic [IN_TDATA_W-1:0] mk_beat(logic [47:0] org, logic [47:0] dst,
      logic [47:0] ctr, logic [47:0] u, logic [47:0] v, logic [47:0] w, logic [47:0] h);
    return {h, w, v, u, ctr, dst, org};
  endfunction

  function automatic logic [47:0] rnd48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // coordinate lane: mostly small so boxes get hit, now and then anywhere
  function automatic int rcoord();
    if ($urandom_range(0, 9) == 0) return int'(16'($urandom));
    return $urandom_range(0, 1600) - 800;
  endfunction

  localparam int ONE = 16384;   // 1.0 in Q1.14

  // well-formed item: a segment near a box with axis-aligned, rotated or random axes
  function automatic logic [IN_TDATA_W-1:0] rnd_query();
    logic [47:0] u, v, w, h;
    int m;
    m = $urandom_range(0, 3);
    case (m)
      0: begin
        u = pack3(ONE, 0, 0); v = pack3(0, ONE, 0); w = pack3(0, 0, ONE);
      end
      1: begin  // 45 deg about z
        u = pack3(11585, 11585, 0); v = pack3(-11585, 11585, 0); w = pack3(0, 0, ONE);
      end
      2: begin
        u = pack3(-ONE, 0, 0); v = pack3(0, 0, ONE); w = pack3(0, -ONE, 0);
      end
      default: begin
        u = rnd48(); v = rnd48(); w = rnd48();
      end
    endcase
    h = pack3($urandom_range(0, 900), $urandom_range(0, 900), $urandom_range(0, 900));
    if ($urandom_range(0, 15) == 0) h = rnd48();
    return mk_beat(pack3(rcoord(), rcoord(), rcoord()), pack3(rcoord(), rcoord(), rcoord()),
                   pack3(rcoord(), rcoord(), rcoord()), u, v, w, h);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_q.size() > 0 &&
            !(phase == 0 && $urandom_range(0, 99) < 32) &&
            !(phase == 1 && $urandom_range(0, 99) < 80)) begin
          s_axis_tdata <= pending_q[0];
          hits_due_q.push_back(predict_isect(pending_q.pop_front()));
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver hold-off: one long stretch once requested
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (hold_req && !hold_taken) begin
      hold_cycles <= 60;
      hold_taken  <= 1'b1;
    end
  end

  // monitor and receiver
  always @(posedge clk_i) begin
    isect_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (hits_due_q.size() == 0) begin
          report_mismatch("unexpected beat", int'(m_axis_tdata), 0);
        end else begin
          want = hits_due_q.pop_front();
          if (m_axis_tdata[0] !== want.hit)
            report_mismatch("hit", int'(m_axis_tdata[0]), int'(want.hit));
          if (m_axis_tdata[16:1] !== want.frac)
            report_mismatch("hit_fraction", int'(m_axis_tdata[16:1]), int'(want.frac));
          if (m_axis_tdata[23:17] !== 7'd0)
            report_mismatch("padding", int'(m_axis_tdata[23:17]), 0);
        end
      end
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
      end else if (phase == 0) m_axis_tready <= ($urandom_range(0, 99) >= 80);
      else if (phase == 1) m_axis_tready <= ($urandom_range(0, 99) >= 32);
      else m_axis_tready <= 1'b1;
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || s_axis_tvalid || hits_due_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    int ax, ay;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: axis-aligned box (half length 64) at the origin, then edge cases
    ax = ONE;
    pending_q.push_back(mk_beat(pack3(-256, 0, 0), pack3(256, 0, 0), pack3(0, 0, 0),
      pack3(ax, 0, 0), pack3(0, ax, 0), pack3(0, 0, ax), pack3(64, 64, 64)));   // plain hit
    pending_q.push_back(mk_beat(pack3(0, 0, 0), pack3(256, 0, 0), pack3(0, 0, 0),
      pack3(ax, 0, 0), pack3(0, ax, 0), pack3(0, 0, ax), pack3(64, 64, 64)));   // origin inside
    pending_q.push_back(mk_beat(pack3(256, 0, 0), pack3(512, 0, 0), pack3(0, 0, 0),
      pack3(ax, 0, 0), pack3(0, ax, 0), pack3(0, 0, ax), pack3(64, 64, 64)));   // box behind
    pending_q.push_back(mk_beat(pack3(-256, 200, 0), pack3(256, 200, 0), pack3(0, 0, 0),
      pack3(ax, 0, 0), pack3(0, ax, 0), pack3(0, 0, ax), pack3(64, 64, 64)));   // parallel outside
    pending_q.push_back(mk_beat(pack3(-256, -64, 0), pack3(256, -64, 0), pack3(0, 0, 0),
      pack3(ax, 0, 0), pack3(0, ax, 0), pack3(0, 0, ax), pack3(64, 64, 64)));   // parallel on face
    pending_q.push_back(mk_beat(pack3(-256, -256, 0), pack3(256, 512, 0), pack3(0, 0, 0),
      pack3(ax, 0, 0), pack3(0, ax, 0), pack3(0, 0, ax), pack3(64, 64, 64)));   // slabs overlap, diagonal hit
    pending_q.push_back(mk_beat(pack3(-256, 0, 0), pack3(-100, 0, 0), pack3(0, 0, 0),
      pack3(ax, 0, 0), pack3(0, ax, 0), pack3(0, 0, ax), pack3(64, 64, 64)));   // ends short
    pending_q.push_back(mk_beat(pack3(10, 10, 10), pack3(10, 10, 10), pack3(0, 0, 0),
      pack3(ax, 0, 0), pack3(0, ax, 0), pack3(0, 0, ax), pack3(64, 64, 64)));   // zero length
    pending_q.push_back(mk_beat(pack3(-256, 0, 0), pack3(256, 0, 0), pack3(0, 0, 0),
      '0, '0, '0, pack3(64, 64, 64)));                                          // degenerate axes
    pending_q.push_back(mk_beat(pack3(-32768, -32768, -32768), pack3(32767, 32767, 32767),
      '0, pack3(-32768, -32768, -32768), pack3(32767, 32767, 32767),
      pack3(-32768, 32767, 0), {48{1'b1}}));                                    // field extremes
    pending_q.push_back(mk_beat({48{1'b1}}, '0, {48{1'b1}}, {48{1'b1}}, {48{1'b1}},
      {48{1'b1}}, '0));
    pending_q.push_back(mk_beat('0, '0, '0, '0, '0, '0, '0));
    pending_q.push_back(mk_beat(pack3(32767, 32767, 32767), pack3(-32768, -32768, -32768),
      pack3(0, 0, 0), pack3(ax, 0, 0), pack3(0, ax, 0), pack3(0, 0, ax),
      pack3(65535, 65535, 65535)));
    ay = -ONE;
    pending_q.push_back(mk_beat(pack3(0, 256, 0), pack3(0, -256, 0), pack3(0, 0, 0),
      pack3(ay, 0, 0), pack3(0, ay, 0), pack3(0, 0, ay), pack3(32, 32, 32)));   // negative axes
    repeat (6) pending_q.push_back(mk_beat(rnd48(), rnd48(), rnd48(), rnd48(), rnd48(),
      rnd48(), rnd48()));
    wait_drained();

    for (int k = 0; k < 180; k++)
      pending_q.push_back($urandom_range(0, 4) == 0 ?
        mk_beat(rnd48(), rnd48(), rnd48(), rnd48(), rnd48(), rnd48(), rnd48()) : rnd_query());
    wait_drained();   // sender pauses until everything is back

    phase = 1;
    for (int k = 0; k < 180; k++) pending_q.push_back(rnd_query());
    wait_drained();

    phase = 2;
    @(posedge clk_i);
    hold_req <= 1'b1;   // long receiver hold-off while items keep coming
    for (int k = 0; k < 190; k++)
      pending_q.push_back($urandom_range(0, 9) == 0 ?
        mk_beat(rnd48(), rnd48(), rnd48(), rnd48(), rnd48(), rnd48(), rnd48()) : rnd_query());
    wait_drained();
    repeat (30) @(posedge clk_i);
    if (errors == 0) $display("PASS ray_obb_segment_intersect");
    else $display("FAIL ray_obb_segment_intersect");
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL ray_obb_segment_intersect");
    $finish;
  end

endmodule

/* ray_obb_segment_intersect.f */
hdl/rosi_pkg.sv
hdl/rosi_frac_cmp.sv
hdl/rosi_div.sv
hdl/ray_obb_segment_intersect.sv
tb/tb_ray_obb_segment_intersect.sv
